// ----- rtl/core/pngh_pkg.sv -----
// ----------------------------------------------------------------------------
// pngh_pkg
// Types, codes and constants shared by the PNG header parser modules.
// ----------------------------------------------------------------------------
package pngh_pkg;

	typedef enum logic [2:0] {
		PH_SIG,
		PH_HEAD,
		PH_SKIP,
		PH_IHDR,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NOT_PNG,
		ST_MALFORMED,
		ST_BAD_INTERLACE,
		ST_UNSUPPORTED,
		ST_PALETTED
	} status_t;

	localparam logic [31:0] CHUNK_IHDR = 32'h4948_4452;

	// IHDR colour types
	localparam logic [7:0] CT_GREY       = 8'd0;
	localparam logic [7:0] CT_RGB        = 8'd2;
	localparam logic [7:0] CT_PALETTE    = 8'd3;
	localparam logic [7:0] CT_GREY_ALPHA = 8'd4;
	localparam logic [7:0] CT_RGBA       = 8'd6;

	// first format code of each colour family
	localparam logic [3:0] FMT_GREY1  = 4'd0;
	localparam logic [3:0] FMT_RGB8   = 4'd4;
	localparam logic [3:0] FMT_GA1    = 4'd6;
	localparam logic [3:0] FMT_RGBA8  = 4'd10;

	typedef struct packed {
		logic [31:0] width;
		logic [31:0] height;
		logic [7:0]  depth;
		logic [7:0]  colour;
		logic [7:0]  compr;
		logic [7:0]  filt;
		logic [7:0]  inter;
	} ihdr_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] width;
		logic [31:0] height;
		logic [7:0]  depth;
		logic [3:0]  fmt;
		logic [2:0]  comps;
		logic [6:0]  bpp;
		logic [3:0]  bytespp;
	} result_t;

	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'h89;
			3'd1: b = 8'h50;
			3'd2: b = 8'h4E;
			3'd3: b = 8'h47;
			3'd4: b = 8'h0D;
			3'd5: b = 8'h0A;
			3'd6: b = 8'h1A;
			3'd7: b = 8'h0A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/core/pngh_judge.sv -----
// ----------------------------------------------------------------------------
// pngh_judge
// Validates captured IHDR fields and derives format, components and pixel size.
// ----------------------------------------------------------------------------
module pngh_judge (
	input  pngh_pkg::ihdr_t   hdr,
	output pngh_pkg::result_t res
);
	import pngh_pkg::*;

	status_t    st;
	logic [3:0] fmt;
	logic [3:0] base;
	logic [2:0] comps;
	logic [6:0] bpp;
	logic [6:0] bsum;
	logic       ok;

	always_comb begin
		st    = ST_OK;
		fmt   = '0;
		base  = '0;
		comps = '0;
		if (hdr.width == '0 || hdr.height == '0 || hdr.compr != '0 || hdr.filt != '0) begin
			st = ST_MALFORMED;
		end else if (hdr.inter > 8'd1) begin
			st = ST_BAD_INTERLACE;
		end else begin
			unique case (hdr.colour)
				CT_GREY, CT_GREY_ALPHA: begin
					base  = (hdr.colour == CT_GREY) ? FMT_GREY1 : FMT_GA1;
					comps = (hdr.colour == CT_GREY) ? 3'd1 : 3'd2;
					unique case (hdr.depth)
						8'd1:    fmt = base;
						8'd2:    fmt = base + 4'd1;
						8'd4:    fmt = base + 4'd2;
						8'd8:    fmt = base + 4'd3;
						default: st  = ST_UNSUPPORTED;
					endcase
				end
				CT_RGB, CT_RGBA: begin
					base  = (hdr.colour == CT_RGB) ? FMT_RGB8 : FMT_RGBA8;
					comps = (hdr.colour == CT_RGB) ? 3'd3 : 3'd4;
					unique case (hdr.depth)
						8'd8:    fmt = base;
						8'd16:   fmt = base + 4'd1;
						default: st  = ST_UNSUPPORTED;
					endcase
				end
				CT_PALETTE: st = ST_PALETTED;
				default:    st = ST_UNSUPPORTED;
			endcase
		end
	end

	assign ok   = (st == ST_OK);
	// depth is at most 16 when ok, so five bits carry it
	assign bpp  = ok ? (7'(hdr.depth[4:0]) * 7'(comps)) : '0;
	assign bsum = bpp + 7'd7;

	assign res.status  = st;
	assign res.width   = hdr.width;
	assign res.height  = hdr.height;
	assign res.depth   = hdr.depth;
	assign res.fmt     = ok ? fmt : '0;
	assign res.comps   = ok ? comps : '0;
	assign res.bpp     = bpp;
	assign res.bytespp = bsum[6:3];

endmodule

// ----- rtl/core/pngh_walker.sv -----
// ----------------------------------------------------------------------------
// pngh_walker
// Per-byte parse state: signature check, chunk walk, IHDR capture, result pick.
// ----------------------------------------------------------------------------
module pngh_walker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        data_byte,
	input  logic              end_of_file,
	output logic              hit,
	output pngh_pkg::result_t res
);
	import pngh_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic        sig_ok_q, sig_ok_d;
	logic [31:0] len_q, len_d;
	logic [23:0] type_q, type_d;
	logic [32:0] skip_q, skip_d;
	logic [31:0] width_q, width_d;
	logic [31:0] height_q, height_d;
	logic [31:0] fields_q, fields_d;

	logic        judge_sel;
	status_t     early_st;
	ihdr_t       hdr;
	result_t     jres;

	// interlace byte is the one in flight on the final IHDR beat
	assign hdr = '{
		width:  width_q,
		height: height_q,
		depth:  fields_q[31:24],
		colour: fields_q[23:16],
		compr:  fields_q[15:8],
		filt:   fields_q[7:0],
		inter:  data_byte
	};

	pngh_judge u_judge (
		.hdr (hdr),
		.res (jres)
	);

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		sig_ok_d  = sig_ok_q;
		len_d     = len_q;
		type_d    = type_q;
		skip_d    = skip_q;
		width_d   = width_q;
		height_d  = height_q;
		fields_d  = fields_q;
		hit       = 1'b0;
		judge_sel = 1'b0;
		early_st  = ST_MALFORMED;

		unique case (phase_q)
			PH_SIG: begin
				if (data_byte != sig_byte(idx_q[2:0])) begin
					sig_ok_d = 1'b0;
				end
				idx_d = idx_q + 4'd1;
				if (idx_q == 4'd7) begin
					if (!sig_ok_d) begin
						hit      = 1'b1;
						early_st = ST_NOT_PNG;
					end else begin
						phase_d = PH_HEAD;
						idx_d   = '0;
					end
				end
			end
			PH_HEAD: begin
				if (idx_q < 4'd4) begin
					len_d = {len_q[23:0], data_byte};
				end else begin
					type_d = {type_q[15:0], data_byte};
				end
				idx_d = idx_q + 4'd1;
				if (idx_q == 4'd7) begin
					if ({type_q, data_byte} == CHUNK_IHDR) begin
						phase_d = PH_IHDR;
						idx_d   = '0;
					end else begin
						// chunk data plus CRC
						phase_d = PH_SKIP;
						skip_d  = {1'b0, len_q} + 33'd4;
					end
				end
			end
			PH_SKIP: begin
				skip_d = skip_q - 33'd1;
				if (skip_q == 33'd1) begin
					phase_d = PH_HEAD;
					idx_d   = '0;
				end
			end
			PH_IHDR: begin
				if (idx_q < 4'd4) begin
					width_d = {width_q[23:0], data_byte};
				end else if (idx_q < 4'd8) begin
					height_d = {height_q[23:0], data_byte};
				end else begin
					fields_d = {fields_q[23:0], data_byte};
				end
				idx_d = idx_q + 4'd1;
				if (idx_q == 4'd12) begin
					hit       = 1'b1;
					judge_sel = 1'b1;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		// early end of file
		if (!hit && end_of_file && phase_q != PH_DONE) begin
			hit      = 1'b1;
			early_st = (phase_d == PH_SIG) ? ST_NOT_PNG : ST_MALFORMED;
		end
		if (hit) begin
			phase_d = PH_DONE;
		end
		if (end_of_file) begin
			phase_d  = PH_SIG;
			idx_d    = '0;
			sig_ok_d = 1'b1;
		end
	end

	always_comb begin
		if (judge_sel) begin
			res = jres;
		end else begin
			res         = '0;
			res.status  = early_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIG;
			idx_q    <= '0;
			sig_ok_q <= 1'b1;
		end else if (fire) begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			sig_ok_q <= sig_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			len_q    <= len_d;
			type_q   <= type_d;
			skip_q   <= skip_d;
			width_q  <= width_d;
			height_q <= height_d;
			fields_q <= fields_d;
		end
	end

endmodule

// ----- rtl/core/png_header_parser_unit.sv -----
// ----------------------------------------------------------------------------
// png_header_parser_unit
// Streams a PNG file byte by byte and reports the IHDR image description.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_stall  | data_byte, end_of_file
//  out     | out_valid/out_stall| status, image_width, image_height, bit_depth,
//          |                    | pixel_format, component_count,
//          |                    | bits_per_pixel, bytes_per_pixel
//
//  One byte per cycle unless held as below; the byte that completes a result
//  passes the input register, then the result register, to the out port.
//  Reset arms the parser for the signature; no clearing pass.
//  While a result waits on out_stall, bytes that give no result still move;
//  the byte that gives the next result holds in the input register.
// ----------------------------------------------------------------------------
module png_header_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] image_width,
	output logic [31:0] image_height,
	output logic [7:0]  bit_depth,
	output logic [3:0]  pixel_format,
	output logic [2:0]  component_count,
	output logic [6:0]  bits_per_pixel,
	output logic [3:0]  bytes_per_pixel
);
	import pngh_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       out_vld_s2;
	result_t    res_s2;

	logic       in_acc;
	logic       fire;
	logic       hit;
	logic       out_free;
	result_t    res;

	assign out_free = !out_vld_s2 || !out_stall;
	assign fire     = vld_s1 && (!hit || out_free);
	assign in_stall = vld_s1 && !fire;
	assign in_acc   = in_valid && !in_stall;

	pngh_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.data_byte   (byte_s1),
		.end_of_file (eof_s1),
		.hit         (hit),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			out_vld_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (out_free) begin
				out_vld_s2 <= fire && hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
		if (fire && hit) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = out_vld_s2;
	assign status          = res_s2.status;
	assign image_width     = res_s2.width;
	assign image_height    = res_s2.height;
	assign bit_depth       = res_s2.depth;
	assign pixel_format    = res_s2.fmt;
	assign component_count = res_s2.comps;
	assign bits_per_pixel  = res_s2.bpp;
	assign bytes_per_pixel = res_s2.bytespp;

endmodule

// ----- rtl/core/pngh_checker.sv -----
// ----------------------------------------------------------------------------
// pngh_checker
// Port-level checks on the PNG header parser, bound to the top level.
// ----------------------------------------------------------------------------
module pngh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  data_byte,
	input logic        end_of_file,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [31:0] image_width,
	input logic [31:0] image_height,
	input logic [7:0]  bit_depth,
	input logic [3:0]  pixel_format,
	input logic [2:0]  component_count,
	input logic [6:0]  bits_per_pixel,
	input logic [3:0]  bytes_per_pixel
);
	import pngh_pkg::*;

	logic [6:0] bpp_calc;
	logic [6:0] bsum;

	assign bpp_calc = 7'(bit_depth[4:0]) * 7'(component_count);
	assign bsum     = bits_per_pixel + 7'd7;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(image_width))
		else $error("result changed while stalled");

	a_ok_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |->
			component_count != 3'd0 && bits_per_pixel == bpp_calc &&
			bytes_per_pixel == bsum[6:3])
		else $error("pixel size does not follow depth and components");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |->
			pixel_format == 4'd0 && component_count == 3'd0 &&
			bits_per_pixel == 7'd0 && bytes_per_pixel == 4'd0)
		else $error("format fields nonzero on an error result");

	a_notpng_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOT_PNG |->
			image_width == 32'd0 && image_height == 32'd0 && bit_depth == 8'd0)
		else $error("not-PNG result carries header values");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a byte beat two cycles earlier");

endmodule

bind png_header_parser_unit pngh_checker u_pngh_checker (.*);

// ----- dv/png_header_parser_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// png_header_parser_unit_test
// Feeds whole PNG byte streams (good headers, bad signatures, truncated files,
// skipped chunks, random noise) through the parser with random gaps on both
// sides and checks every result beat against an in-bench header predictor.
// ----------------------------------------------------------------------------
module png_header_parser_unit_test;

	import pngh_pkg::*;

	localparam int          CLK_PERIOD   = 20;
	localparam int unsigned RANDOM_BYTES = 2000;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned HOLD_AT      = 6;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned LIMIT_CYCLES = 400_000;
	localparam int          NO_FLAW      = -1;

	localparam logic [63:0] PNG_SIG = 64'h8950_4E47_0D0A_1A0A;

	localparam ihdr_t   PLAIN_HDR       = '{32'd1, 32'd1, 8'd8, CT_GREY, 8'd0, 8'd0, 8'd0};
	localparam result_t NOT_PNG_RES     = '{ST_NOT_PNG, 32'd0, 32'd0, 8'd0, 4'd0, 3'd0, 7'd0, 4'd0};
	localparam result_t EARLY_MALFORMED = '{ST_MALFORMED, 32'd0, 32'd0, 8'd0, 4'd0, 3'd0, 7'd0, 4'd0};
	localparam result_t UNTYPED         = '0;

	typedef struct {
		int          bad_at;    // signature byte to corrupt
		int unsigned skips;     // chunks ahead of IHDR
		int unsigned skip_len;
		int unsigned ihdr_len;  // length field, not checked by the block
		ihdr_t       hdr;
		int unsigned cut;       // bytes kept before eof, 0 keeps the whole file
		int unsigned tail;      // bytes after the IHDR data
		bit          typed;
		result_t     want;
	} file_plan_t;

	file_plan_t directed_files [23] = '{
		// eof on the first byte
		'{NO_FLAW, 0, 0, 13, PLAIN_HDR, 1, 0, 1'b1, NOT_PNG_RES},
		// bad first / last signature byte, rest of file ignored
		'{0, 0, 0, 13, PLAIN_HDR, 0, 4, 1'b1, NOT_PNG_RES},
		'{7, 0, 0, 13, PLAIN_HDR, 0, 4, 1'b1, NOT_PNG_RES},
		// signature only
		'{NO_FLAW, 0, 0, 13, PLAIN_HDR, 8, 0, 1'b1, EARLY_MALFORMED},
		// eof inside the IHDR data
		'{NO_FLAW, 1, 0, 13, PLAIN_HDR, 33, 0, 1'b1, EARLY_MALFORMED},
		// eof while still skipping, no IHDR seen
		'{NO_FLAW, 2, 3, 13, PLAIN_HDR, 20, 0, 1'b1, EARLY_MALFORMED},
		// smallest image, zero length field
		'{NO_FLAW, 1, 5, 0, '{32'd1, 32'd1, 8'd1, CT_GREY, 8'd0, 8'd0, 8'd0}, 0, 4,
		  1'b1, '{ST_OK, 32'd1, 32'd1, 8'd1, FMT_GREY1, 3'd1, 7'd1, 4'd1}},
		// largest image, eof on the last IHDR byte
		'{NO_FLAW, 0, 0, 13, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd16, CT_RGBA, 8'd0, 8'd0, 8'd1},
		  0, 0, 1'b1,
		  '{ST_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd16, FMT_RGBA8 + 4'd1, 3'd4, 7'd64, 4'd8}},
		'{NO_FLAW, 0, 0, 13, '{32'd0, 32'd5, 8'd8, CT_GREY, 8'd0, 8'd0, 8'd0}, 0, 4,
		  1'b1, '{ST_MALFORMED, 32'd0, 32'd5, 8'd8, 4'd0, 3'd0, 7'd0, 4'd0}},
		// zero height wins over palette
		'{NO_FLAW, 0, 0, 13, '{32'd7, 32'd0, 8'd8, CT_PALETTE, 8'd0, 8'd0, 8'd0}, 0, 4,
		  1'b1, '{ST_MALFORMED, 32'd7, 32'd0, 8'd8, 4'd0, 3'd0, 7'd0, 4'd0}},
		'{NO_FLAW, 0, 0, 13, '{32'd3, 32'd3, 8'd8, CT_RGB, 8'd255, 8'd0, 8'd0}, 0, 4,
		  1'b1, '{ST_MALFORMED, 32'd3, 32'd3, 8'd8, 4'd0, 3'd0, 7'd0, 4'd0}},
		'{NO_FLAW, 0, 0, 13, '{32'd3, 32'd3, 8'd8, CT_RGB, 8'd0, 8'd1, 8'd0}, 0, 4,
		  1'b1, '{ST_MALFORMED, 32'd3, 32'd3, 8'd8, 4'd0, 3'd0, 7'd0, 4'd0}},
		// interlace wins over palette
		'{NO_FLAW, 0, 0, 13, '{32'd2, 32'd2, 8'd8, CT_PALETTE, 8'd0, 8'd0, 8'd2}, 0, 4,
		  1'b1, '{ST_BAD_INTERLACE, 32'd2, 32'd2, 8'd8, 4'd0, 3'd0, 7'd0, 4'd0}},
		'{NO_FLAW, 0, 0, 13, '{32'd2, 32'd2, 8'd8, CT_GREY, 8'd0, 8'd0, 8'd255}, 0, 4,
		  1'b1, '{ST_BAD_INTERLACE, 32'd2, 32'd2, 8'd8, 4'd0, 3'd0, 7'd0, 4'd0}},
		'{NO_FLAW, 0, 0, 13, '{32'd4, 32'd4, 8'd8, CT_PALETTE, 8'd0, 8'd0, 8'd0}, 0, 4,
		  1'b1, '{ST_PALETTED, 32'd4, 32'd4, 8'd8, 4'd0, 3'd0, 7'd0, 4'd0}},
		'{NO_FLAW, 0, 0, 13, '{32'd4, 32'd4, 8'd8, 8'd255, 8'd0, 8'd0, 8'd0}, 0, 4,
		  1'b1, '{ST_UNSUPPORTED, 32'd4, 32'd4, 8'd8, 4'd0, 3'd0, 7'd0, 4'd0}},
		'{NO_FLAW, 0, 0, 13, '{32'd4, 32'd4, 8'd16, CT_GREY, 8'd0, 8'd0, 8'd0}, 0, 4,
		  1'b1, '{ST_UNSUPPORTED, 32'd4, 32'd4, 8'd16, 4'd0, 3'd0, 7'd0, 4'd0}},
		'{NO_FLAW, 0, 0, 13, '{32'd4, 32'd4, 8'd4, CT_RGB, 8'd0, 8'd0, 8'd0}, 0, 4,
		  1'b1, '{ST_UNSUPPORTED, 32'd4, 32'd4, 8'd4, 4'd0, 3'd0, 7'd0, 4'd0}},
		'{NO_FLAW, 1, 2, 13, '{32'd9, 32'd3, 8'd2, CT_GREY_ALPHA, 8'd0, 8'd0, 8'd1}, 0, 6,
		  1'b0, UNTYPED},
		'{NO_FLAW, 0, 0, 13, '{32'd640, 32'd480, 8'd16, CT_RGB, 8'd0, 8'd0, 8'd0}, 0, 4,
		  1'b0, UNTYPED},
		'{NO_FLAW, 0, 0, 13, '{32'd100, 32'd1, 8'd4, CT_GREY, 8'd0, 8'd0, 8'd1}, 0, 4,
		  1'b0, UNTYPED},
		'{NO_FLAW, 0, 0, 13, '{32'd1, 32'd200, 8'd8, CT_GREY_ALPHA, 8'd0, 8'd0, 8'd0}, 0, 0,
		  1'b0, UNTYPED},
		'{NO_FLAW, 0, 0, 13, '{32'd33, 32'd17, 8'd8, CT_GREY, 8'd0, 8'd0, 8'd0}, 0, 30,
		  1'b0, UNTYPED}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        end_of_file;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [31:0] image_width;
	logic [31:0] image_height;
	logic [7:0]  bit_depth;
	logic [3:0]  pixel_format;
	logic [2:0]  component_count;
	logic [6:0]  bits_per_pixel;
	logic [3:0]  bytes_per_pixel;

	// header predictor state
	phase_t      walk_phase;
	logic [32:0] walk_count;
	bit          sig_intact;
	logic [31:0] len_shift;
	logic [31:0] type_shift;
	logic [31:0] width_shift;
	logic [31:0] height_shift;
	logic [39:0] field_shift;

	result_t     expected_headers [$];
	logic [7:0]  file_bytes [$];
	int          mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned send_calm  = 100;
	bit          hold_req   = 1'b0;

	png_header_parser_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.end_of_file     (end_of_file),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.image_width     (image_width),
		.image_height    (image_height),
		.bit_depth       (bit_depth),
		.pixel_format    (pixel_format),
		.component_count (component_count),
		.bits_per_pixel  (bits_per_pixel),
		.bytes_per_pixel (bytes_per_pixel)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int unsigned pick_gap(input int unsigned calm_pct);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < calm_pct)
			return 0;
		if (roll < 96)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] draw_dim();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return 32'd0;
		if (roll < 10)
			return 32'hFFFF_FFFF;
		if (roll < 70)
			return $urandom_range(1, 64);
		return $urandom;
	endfunction

	function automatic result_t make_result(input status_t st, input logic [31:0] w,
	                                        input logic [31:0] h, input logic [7:0] depth,
	                                        input logic [3:0] fmt, input logic [2:0] comps);
		result_t     r;
		logic [10:0] bits;
		logic [10:0] whole;
		bits      = (st == ST_OK) ? depth * comps : 11'd0;
		whole     = (bits + 11'd7) >> 3;
		r.status  = st;
		r.width   = w;
		r.height  = h;
		r.depth   = depth;
		r.fmt     = (st == ST_OK) ? fmt : 4'd0;
		r.comps   = (st == ST_OK) ? comps : 3'd0;
		r.bpp     = bits[6:0];
		r.bytespp = whole[3:0];
		return r;
	endfunction

	task automatic rearm_parser();
		walk_phase   = PH_SIG;
		walk_count   = '0;
		sig_intact   = 1'b1;
		len_shift    = '0;
		type_shift   = '0;
		width_shift  = '0;
		height_shift = '0;
		field_shift  = '0;
	endtask

	// advances the predictor by one byte; hit is set when the byte gives a result
	task automatic parse_byte(input logic [7:0] b, input logic eof,
	                          output bit hit, output result_t r);
		logic [7:0] depth, colour, compr, filt, inter;
		status_t    st;
		logic [3:0] fmt;
		logic [2:0] comps;
		hit = 1'b0;
		r   = '0;
		case (walk_phase)
			PH_SIG: begin
				if (walk_count < 8 && b != PNG_SIG[63 - 8 * walk_count[2:0] -: 8])
					sig_intact = 1'b0;
				walk_count++;
				if (walk_count >= 8) begin
					if (!sig_intact) begin
						r   = make_result(ST_NOT_PNG, '0, '0, '0, '0, '0);
						hit = 1'b1;
					end else begin
						walk_phase = PH_HEAD;
						walk_count = '0;
					end
				end
			end
			PH_HEAD: begin
				if (walk_count < 4)
					len_shift = {len_shift[23:0], b};
				else
					type_shift = {type_shift[23:0], b};
				walk_count++;
				if (walk_count >= 8) begin
					if (type_shift == CHUNK_IHDR) begin
						walk_phase = PH_IHDR;
						walk_count = '0;
					end else begin
						walk_phase = PH_SKIP;
						walk_count = {1'b0, len_shift} + 33'd4;
					end
				end
			end
			PH_SKIP: begin
				if (walk_count > 0)
					walk_count--;
				if (walk_count == 0) begin
					walk_phase = PH_HEAD;
					len_shift  = '0;
					type_shift = '0;
				end
			end
			PH_IHDR: begin
				if (walk_count < 4)
					width_shift = {width_shift[23:0], b};
				else if (walk_count < 8)
					height_shift = {height_shift[23:0], b};
				else
					field_shift = {field_shift[31:0], b};
				walk_count++;
				if (walk_count >= 13) begin
					{depth, colour, compr, filt, inter} = field_shift;
					st    = ST_OK;
					fmt   = '0;
					comps = '0;
					// first failing rule wins
					if (width_shift == 0 || height_shift == 0 || compr != 0 || filt != 0) begin
						st = ST_MALFORMED;
					end else if (inter > 8'd1) begin
						st = ST_BAD_INTERLACE;
					end else if (colour == CT_GREY || colour == CT_GREY_ALPHA) begin
						fmt   = (colour == CT_GREY) ? FMT_GREY1 : FMT_GA1;
						comps = (colour == CT_GREY) ? 3'd1 : 3'd2;
						case (depth)
							8'd1: ;
							8'd2: fmt += 4'd1;
							8'd4: fmt += 4'd2;
							8'd8: fmt += 4'd3;
							default: st = ST_UNSUPPORTED;
						endcase
					end else if (colour == CT_RGB || colour == CT_RGBA) begin
						fmt   = (colour == CT_RGB) ? FMT_RGB8 : FMT_RGBA8;
						comps = (colour == CT_RGB) ? 3'd3 : 3'd4;
						if (depth == 8'd16)
							fmt += 4'd1;
						else if (depth != 8'd8)
							st = ST_UNSUPPORTED;
					end else if (colour == CT_PALETTE) begin
						st = ST_PALETTED;
					end else begin
						st = ST_UNSUPPORTED;
					end
					r   = make_result(st, width_shift, height_shift, depth, fmt, comps);
					hit = 1'b1;
				end
			end
			default: ;
		endcase
		if (!hit && eof && walk_phase != PH_DONE) begin
			if (walk_phase == PH_SIG)
				r = make_result(ST_NOT_PNG, '0, '0, '0, '0, '0);
			else
				r = make_result(ST_MALFORMED, '0, '0, '0, '0, '0);
			hit = 1'b1;
		end
		if (hit)
			walk_phase = PH_DONE;
		if (eof)
			rearm_parser();
	endtask

	// sends file_bytes, eof on the last one; called and returns at a rising edge
	task automatic feed_file(input bit typed, input result_t want);
		bit          hit;
		bit          taken;
		result_t     r;
		int unsigned gap;
		logic        eof;
		foreach (file_bytes[i]) begin
			eof = (i == file_bytes.size() - 1);
			parse_byte(file_bytes[i], eof, hit, r);
			if (hit)
				expected_headers.push_back(typed ? want : r);
			gap = pick_gap(send_calm);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid    <= 1'b1;
			data_byte   <= file_bytes[i];
			end_of_file <= eof;
			// stall sampled mid-cycle, beat taken at the next edge
			do begin
				@(negedge clk);
				taken = !in_stall;
				@(posedge clk);
			end while (!taken);
			bytes_sent++;
		end
	endtask

	task automatic send_file(input file_plan_t p);
		logic [103:0] hdr_bits;
		logic [31:0]  len;
		int           i;
		file_bytes.delete();
		for (i = 0; i < 8; i++)
			file_bytes.push_back(PNG_SIG[63 - 8 * i -: 8] ^ ((i == p.bad_at) ? 8'hFF : 8'h00));
		repeat (p.skips) begin
			len = p.skip_len;
			for (i = 0; i < 4; i++)
				file_bytes.push_back(len[31 - 8 * i -: 8]);
			// lower-case first letter keeps the type off IHDR
			file_bytes.push_back(8'($urandom_range(97, 122)));
			repeat (3) file_bytes.push_back(8'($urandom_range(65, 122)));
			repeat (p.skip_len + 4) file_bytes.push_back(8'($urandom_range(0, 255)));
		end
		len = p.ihdr_len;
		for (i = 0; i < 4; i++)
			file_bytes.push_back(len[31 - 8 * i -: 8]);
		for (i = 0; i < 4; i++)
			file_bytes.push_back(CHUNK_IHDR[31 - 8 * i -: 8]);
		hdr_bits = p.hdr;
		for (i = 0; i < 13; i++)
			file_bytes.push_back(hdr_bits[103 - 8 * i -: 8]);
		repeat (p.tail) file_bytes.push_back(8'($urandom_range(0, 255)));
		if (p.cut != 0)
			while (file_bytes.size() > p.cut)
				void'(file_bytes.pop_back());
		feed_file(p.typed, p.want);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_headers.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
	                             input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	initial begin : stimulus
		file_plan_t  plan;
		int unsigned file_no;
		int unsigned roll;
		int unsigned n;
		int          i;
		bit          lead_sig;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		data_byte   <= 8'h00;
		end_of_file <= 1'b0;
		rearm_parser();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_files[k]) begin
			send_calm = (k % 3 == 0) ? 100 : $urandom_range(0, 90);
			send_file(directed_files[k]);
		end
		wait_drained();

		file_no = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			if (file_no == HOLD_AT)
				hold_req = 1'b1;
			if (file_no >= HOLD_AT && file_no < HOLD_AT + 12)
				send_calm = 100;
			else
				case ($urandom_range(0, 3))
					0: send_calm = 100;
					1: send_calm = 90;
					2: send_calm = 50;
					default: send_calm = 0;
				endcase
			if (file_no % 16 == 15)
				wait_drained();
			roll = $urandom_range(0, 99);
			if (roll < 85) begin
				plan.bad_at   = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 7))
				                                             : NO_FLAW;
				plan.skips    = $urandom_range(0, 2);
				plan.skip_len = $urandom_range(0, 12);
				plan.ihdr_len = ($urandom_range(0, 3) == 0) ? $urandom : 13;
				plan.hdr.width  = draw_dim();
				plan.hdr.height = draw_dim();
				case ($urandom_range(0, 5))
					0: plan.hdr.depth = 8'd1;
					1: plan.hdr.depth = 8'd2;
					2: plan.hdr.depth = 8'd4;
					3: plan.hdr.depth = 8'd8;
					4: plan.hdr.depth = 8'd16;
					default: plan.hdr.depth = 8'($urandom_range(0, 255));
				endcase
				case ($urandom_range(0, 5))
					0: plan.hdr.colour = CT_GREY;
					1: plan.hdr.colour = CT_RGB;
					2: plan.hdr.colour = CT_PALETTE;
					3: plan.hdr.colour = CT_GREY_ALPHA;
					4: plan.hdr.colour = CT_RGBA;
					default: plan.hdr.colour = 8'($urandom_range(0, 255));
				endcase
				plan.hdr.compr = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255))
				                                              : 8'd0;
				plan.hdr.filt  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255))
				                                              : 8'd0;
				plan.hdr.inter = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(2, 255))
				                                              : 8'($urandom_range(0, 1));
				// some well-formed files end early
				plan.cut   = (roll >= 70) ? $urandom_range(1, 50) : 0;
				plan.tail  = $urandom_range(0, 12);
				plan.typed = 1'b0;
				plan.want  = UNTYPED;
				send_file(plan);
			end else begin
				// noise, often behind a good signature so chunk walking sees junk
				file_bytes.delete();
				n        = $urandom_range(1, 40);
				lead_sig = $urandom_range(0, 1);
				for (i = 0; i < n; i++)
					file_bytes.push_back((lead_sig && i < 8) ? PNG_SIG[63 - 8 * i -: 8]
					                                         : 8'($urandom_range(0, 255)));
				feed_file(1'b0, UNTYPED);
			end
			file_no++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_headers.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : result_drain
		int unsigned calm;
		int unsigned left;
		int unsigned n;
		out_stall <= 1'b0;
		calm = 100;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// long hold-off: parser fills and pushes back on the sender
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				if (left == 0) begin
					calm = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(20, 80);
					left = $urandom_range(50, 300);
				end
				left--;
				n = pick_gap(calm);
				if (n == 0) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// outputs settle after the rising edge; a beat seen here lands on the next edge
	always @(negedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_headers.size() == 0) begin
				$error("result beat with nothing expected, status %0d", status);
				mismatches++;
			end else begin
				want = expected_headers.pop_front();
				compare_field("status", 32'(want.status), 32'(status));
				compare_field("image_width", want.width, image_width);
				compare_field("image_height", want.height, image_height);
				compare_field("bit_depth", 32'(want.depth), 32'(bit_depth));
				compare_field("pixel_format", 32'(want.fmt), 32'(pixel_format));
				compare_field("component_count", 32'(want.comps), 32'(component_count));
				compare_field("bits_per_pixel", 32'(want.bpp), 32'(bits_per_pixel));
				compare_field("bytes_per_pixel", 32'(want.bytespp), 32'(bytes_per_pixel));
			end
		end
	end

	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
